### design/spherical_feature_transform_top_macros.svh
// ----------------------------------------------------------------------------
// Spherical feature transform assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_FEATURE_TRANSFORM_TOP_MACROS_SVH
`define SPHERICAL_FEATURE_TRANSFORM_TOP_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define SFT_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define SFT_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

### design/sft_pkg.sv
// ----------------------------------------------------------------------------
// Spherical feature transform package
// Shared constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package sft_pkg;

    // Angle format: signed radians, 29 fraction bits
    localparam int ANG_FRAC  = 29;
    localparam int ANG_W     = 33;
    localparam int PRESCALE  = 16;
    localparam int GAIN_FRAC = 8;
    localparam int ARC_SHIFT = ANG_FRAC + GAIN_FRAC - 32;

    localparam int CORDIC_LANES = 2;
    localparam int ROM_SIZE     = 32;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_RANGE_REFERENCE = 3'd0;
    localparam cfg_idx_t CFG_RANGE_GAIN      = 3'd1;
    localparam cfg_idx_t CFG_AZIMUTH_GAIN    = 3'd2;
    localparam cfg_idx_t CFG_ELEVATION_GAIN  = 3'd3;
    localparam cfg_idx_t CFG_BALANCE_ENABLE  = 3'd4;

    localparam logic [CFG_W-1:0] RST_RANGE_REFERENCE = 16'd2000;
    localparam logic [CFG_W-1:0] RST_RANGE_GAIN      = 16'd896;
    localparam logic [CFG_W-1:0] RST_AZIMUTH_GAIN    = 16'd256;
    localparam logic [CFG_W-1:0] RST_ELEVATION_GAIN  = 16'd256;

    // Result fields
    localparam int RANGE_F_W   = 39;
    localparam int ARC_F_W     = 40;
    localparam int OUT_FIELD_W = RANGE_F_W + 2 * ARC_F_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic [RANGE_F_W-1:0] range_f_t;
    typedef logic [ARC_F_W-1:0]   arc_f_t;

    localparam range_f_t RANGE_MAX = {RANGE_F_W{1'b1}};

    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t PI_Q = 33'sd1686629713;

    // atan(2^-i) in radians, 29 fraction bits, rounded
    function automatic ang_t atan_q29(int i);
        ang_t v;
        case (i)
            0:       v = 33'sd421657428;
            1:       v = 33'sd248918915;
            2:       v = 33'sd131521918;
            3:       v = 33'sd66762579;
            4:       v = 33'sd33510843;
            5:       v = 33'sd16771758;
            6:       v = 33'sd8387925;
            7:       v = 33'sd4194219;
            8:       v = 33'sd2097141;
            9:       v = 33'sd1048575;
            10:      v = 33'sd524288;
            11:      v = 33'sd262144;
            12:      v = 33'sd131072;
            13:      v = 33'sd65536;
            14:      v = 33'sd32768;
            15:      v = 33'sd16384;
            16:      v = 33'sd8192;
            17:      v = 33'sd4096;
            18:      v = 33'sd2048;
            19:      v = 33'sd1024;
            20:      v = 33'sd512;
            21:      v = 33'sd256;
            22:      v = 33'sd128;
            23:      v = 33'sd64;
            24:      v = 33'sd32;
            25:      v = 33'sd16;
            26:      v = 33'sd8;
            27:      v = 33'sd4;
            28:      v = 33'sd2;
            29:      v = 33'sd1;
            30:      v = 33'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/sft_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, then a round-to-nearest stage; a tag rides along.
// ----------------------------------------------------------------------------
module sft_sqrt #(
    parameter int IN_W  = 50,
    parameter int TAG_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_rad,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [TAG_W-1:0]    out_tag
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 3;

    logic [IN_W-1:0]  rad_reg  [1:OUT_W-1];
    logic [OUT_W-1:0] root_reg [1:OUT_W];
    logic [RW-1:0]    rem_reg  [1:OUT_W];
    logic             vld_reg  [1:OUT_W];
    logic [TAG_W-1:0] tag_reg  [1:OUT_W];

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_root_reg;
    logic [TAG_W-1:0] out_tag_reg;

    genvar k;
    generate
        for (k = 1; k <= OUT_W; k++) begin : g_stage
            logic [IN_W-1:0]  prev_rad;
            logic [OUT_W-1:0] prev_root;
            logic [RW-1:0]    prev_rem;
            logic             prev_vld;
            logic [TAG_W-1:0] prev_tag;
            logic [RW-1:0]    rem_sh;
            logic [RW-1:0]    trial;
            logic             take;

            if (k == 1) begin : g_first
                assign prev_rad  = in_rad;
                assign prev_root = '0;
                assign prev_rem  = '0;
                assign prev_vld  = in_valid;
                assign prev_tag  = in_tag;
            end
            else begin : g_next
                assign prev_rad  = rad_reg[k-1];
                assign prev_root = root_reg[k-1];
                assign prev_rem  = rem_reg[k-1];
                assign prev_vld  = vld_reg[k-1];
                assign prev_tag  = tag_reg[k-1];
            end

            // bring down the next bit pair, try subtracting 4*root+1
            assign rem_sh = {prev_rem[RW-3:0], prev_rad[IN_W-1 -: 2]};
            assign trial  = RW'({prev_root, 2'b01});
            assign take   = (rem_sh >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= prev_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[k] <= {prev_root[OUT_W-2:0], take};
                    rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                    tag_reg[k]  <= prev_tag;
                end
            end

            if (k < OUT_W) begin : g_rad
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rad_reg[k] <= prev_rad << 2;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[OUT_W];
        end
    end

    // round to nearest: bump when the remainder exceeds the root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_root_reg <= root_reg[OUT_W]
                          + OUT_W'(rem_reg[OUT_W] > RW'(root_reg[OUT_W]));
            out_tag_reg  <= tag_reg[OUT_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_root  = out_root_reg;
    assign out_tag   = out_tag_reg;

endmodule

### design/sft_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// Two vectoring lanes computing atan2(y, x) with one rotation per stage.
// ----------------------------------------------------------------------------
module sft_cordic
    import sft_pkg::*;
#(
    parameter int IN_W   = 25,
    parameter int STAGES = 24,
    parameter int TAG_W  = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [IN_W-1:0]  in_y [CORDIC_LANES],
    input  logic signed [IN_W-1:0]  in_x [CORDIC_LANES],
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] out_ang [CORDIC_LANES],
    output logic [TAG_W-1:0]        out_tag
);

    // headroom: negation, prescale, CORDIC gain and the diagonal
    localparam int WW = IN_W + PRESCALE + 4;

    logic             vld_reg [0:STAGES];
    logic [TAG_W-1:0] tag_reg [0:STAGES];
    logic             out_valid_reg;
    logic [TAG_W-1:0] out_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
        end
    end

    genvar k, ln;
    generate
        for (k = 1; k <= STAGES; k++) begin : g_ctl
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg[k] <= tag_reg[k-1];
                end
            end
        end

        for (ln = 0; ln < CORDIC_LANES; ln++) begin : g_lane
            logic signed [WW-1:0]    x_reg    [0:STAGES];
            logic signed [WW-1:0]    y_reg    [0:STAGES];
            logic signed [ANG_W-1:0] acc_reg  [0:STAGES];
            logic signed [ANG_W-1:0] base_reg [0:STAGES];
            logic                    zero_reg [0:STAGES];
            logic signed [ANG_W-1:0] ang_reg;

            logic signed [IN_W:0]    xe;
            logic signed [IN_W:0]    ye;
            logic signed [IN_W:0]    xa;
            logic signed [IN_W:0]    ya;
            logic                    xneg;
            logic                    yzero;
            logic                    ypos;
            logic signed [ANG_W-1:0] base;

            // fold the left half plane onto the right and note the offset
            always_comb
            begin
                xe    = (IN_W+1)'(in_x[ln]);
                ye    = (IN_W+1)'(in_y[ln]);
                xneg  = in_x[ln][IN_W-1];
                yzero = (in_y[ln] == '0);
                ypos  = !in_y[ln][IN_W-1] && !yzero;
                xa    = xneg ? -xe : xe;
                ya    = xneg ? -ye : ye;
                if (yzero)
                begin
                    base = xneg ? PI_Q : '0;
                end
                else if (xneg)
                begin
                    base = ypos ? PI_Q : -PI_Q;
                end
                else
                begin
                    base = '0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[0]    <= WW'(xa) <<< PRESCALE;
                    y_reg[0]    <= WW'(ya) <<< PRESCALE;
                    acc_reg[0]  <= '0;
                    base_reg[0] <= base;
                    zero_reg[0] <= yzero;
                end
            end

            for (k = 1; k <= STAGES; k++) begin : g_rot
                logic signed [WW-1:0] dx;
                logic signed [WW-1:0] dy;
                logic                 up;

                assign dx = y_reg[k-1] >>> (k-1);
                assign dy = x_reg[k-1] >>> (k-1);
                assign up = !y_reg[k-1][WW-1] && (y_reg[k-1] != '0);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        x_reg[k]    <= up ? (x_reg[k-1] + dx) : (x_reg[k-1] - dx);
                        y_reg[k]    <= up ? (y_reg[k-1] - dy) : (y_reg[k-1] + dy);
                        acc_reg[k]  <= up ? (acc_reg[k-1] + atan_q29(k-1))
                                          : (acc_reg[k-1] - atan_q29(k-1));
                        base_reg[k] <= base_reg[k-1];
                        zero_reg[k] <= zero_reg[k-1];
                    end
                end
            end

            // with y zero the angle is exactly the offset
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ang_reg <= zero_reg[STAGES] ? base_reg[STAGES]
                                                : (base_reg[STAGES] + acc_reg[STAGES]);
                end
            end

            assign out_ang[ln] = ang_reg;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_tag_reg <= tag_reg[STAGES];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;

endmodule

### design/spherical_feature_transform_top.sv
// ----------------------------------------------------------------------------
// Spherical feature transform
// Converts a Cartesian point into weighted range, azimuth and elevation.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries one point per transaction: px, py, pz in two's complement
//   with FRAC_BITS fraction bits. m_* returns one feature point per input
//   point, in order: range_feature, azimuth_feature, elevation_feature.
//   cfg_* writes one register per transaction (index, 16-bit data); it is
//   always ready. Write registers only while no point is in flight.
// Throughput: one point per cycle unless the output stalls; fully pipelined.
// Path: capture, squares, sums, the range and horizontal square roots side
//   by side, the CORDIC stages, range times reference, the scale square root,
//   then the products, the gain partial products and the output register.
// Reset: clears all valid bits and loads the register defaults
//   (reference 2000, range gain 3.5, angle gains 1.0, balancing on).
// Stall: the whole pipeline advances together; when m_tvalid is high and
//   m_tready is low every stage holds and s_tready drops, so nothing is
//   lost or repeated. An empty output register never blocks the input.
// ----------------------------------------------------------------------------
module spherical_feature_transform_top
    import sft_pkg::*;
#(
    parameter int COORD_WIDTH   = 24,
    parameter int FRAC_BITS     = 8,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // px [CW-1:0], py [2CW-1:CW], pz [3CW-1:2CW], zero fill above
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // range_feature [38:0], azimuth_feature [78:39], elevation_feature
    // [118:79], zero fill above
    output logic [OUT_TDATA_W-1:0]              m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_W-1:0]                    cfg_data
);

    localparam int CW       = COORD_WIDTH;
    localparam int SQ_IN_W  = 2 * CW + 2;
    localparam int R_W      = CW + 1;
    localparam int P4_W     = R_W + CFG_W;
    localparam int P_RAW_W  = P4_W + FRAC_BITS;
    localparam int P_W      = P_RAW_W + (P_RAW_W % 2);
    localparam int S_ROOT_W = P_W / 2;
    localparam int SCALE_W  = (S_ROOT_W > R_W) ? S_ROOT_W : R_W;
    localparam int RF_W     = P4_W + 1;
    localparam int LO_W     = 32 + CFG_W + 1;
    localparam int HI_W     = 32 + CFG_W;
    localparam int T_W      = HI_W + 1;
    localparam int SC_TAG_W = 2 * ANG_W + R_W;

    localparam logic [LO_W-1:0] ROUND_ARC = LO_W'(1) << (ANG_FRAC + GAIN_FRAC - 1);
    localparam logic [RF_W-1:0] ROUND_RF  = RF_W'(1) << (GAIN_FRAC - 1);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] range_reference_reg;
    logic [CFG_W-1:0] range_gain_reg;
    logic [CFG_W-1:0] azimuth_gain_reg;
    logic [CFG_W-1:0] elevation_gain_reg;
    logic             balance_enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reference_reg <= RST_RANGE_REFERENCE;
            range_gain_reg      <= RST_RANGE_GAIN;
            azimuth_gain_reg    <= RST_AZIMUTH_GAIN;
            elevation_gain_reg  <= RST_ELEVATION_GAIN;
            balance_enable_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RANGE_REFERENCE: range_reference_reg <= cfg_data;
                CFG_RANGE_GAIN:      range_gain_reg      <= cfg_data;
                CFG_AZIMUTH_GAIN:    azimuth_gain_reg    <= cfg_data;
                CFG_ELEVATION_GAIN:  elevation_gain_reg  <= cfg_data;
                CFG_BALANCE_ENABLE:  balance_enable_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // ---------------- global advance ----------------
    // Every stage moves when the output register is empty or being drained.
    logic m_tvalid_reg;
    logic en;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: capture the point ----------------
    logic                 v1_reg;
    logic signed [CW-1:0] x1_reg, y1_reg, z1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= $signed(s_tdata[CW-1:0]);
            y1_reg <= $signed(s_tdata[2*CW-1:CW]);
            z1_reg <= $signed(s_tdata[3*CW-1:2*CW]);
        end
    end

    // ---------------- stage 2: magnitudes squared ----------------
    logic [CW-1:0]        ax1, ay1, az1;
    logic                 v2_reg;
    logic [2*CW-1:0]      sqx2_reg, sqy2_reg, sqz2_reg;
    logic signed [CW-1:0] x2_reg, y2_reg, z2_reg;

    // the most negative value maps to its unsigned magnitude
    assign ax1 = x1_reg[CW-1] ? (~x1_reg + 1'b1) : x1_reg;
    assign ay1 = y1_reg[CW-1] ? (~y1_reg + 1'b1) : y1_reg;
    assign az1 = z1_reg[CW-1] ? (~z1_reg + 1'b1) : z1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx2_reg <= (2*CW)'(ax1) * (2*CW)'(ax1);
            sqy2_reg <= (2*CW)'(ay1) * (2*CW)'(ay1);
            sqz2_reg <= (2*CW)'(az1) * (2*CW)'(az1);
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
        end
    end

    // ---------------- stage 3: sums of squares ----------------
    logic                 v3_reg;
    logic [SQ_IN_W-1:0]   sxy3_reg, sall3_reg;
    logic signed [CW-1:0] x3_reg, y3_reg, z3_reg;
    logic [SQ_IN_W-1:0]   sxy2;

    assign sxy2 = SQ_IN_W'(sqx2_reg) + SQ_IN_W'(sqy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxy3_reg  <= sxy2;
            sall3_reg <= sxy2 + SQ_IN_W'(sqz2_reg);
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            z3_reg    <= z2_reg;
        end
    end

    // ---------------- range and horizontal distance ----------------
    logic            vr, vh;
    logic [R_W-1:0]  r_root, h_root;
    logic [2*CW-1:0] xy_tag;
    logic [CW-1:0]   z_tag;

    sft_sqrt #(
        .IN_W  (SQ_IN_W),
        .TAG_W (2 * CW)
    ) u_sqrt_range (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (sall3_reg),
        .in_tag    ({x3_reg, y3_reg}),
        .out_valid (vr),
        .out_root  (r_root),
        .out_tag   (xy_tag)
    );

    sft_sqrt #(
        .IN_W  (SQ_IN_W),
        .TAG_W (CW)
    ) u_sqrt_horiz (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (sxy3_reg),
        .in_tag    (z3_reg),
        .out_valid (vh),
        .out_root  (h_root),
        .out_tag   (z_tag)
    );

    // ---------------- azimuth and elevation ----------------
    logic signed [R_W-1:0]   cin_y [CORDIC_LANES];
    logic signed [R_W-1:0]   cin_x [CORDIC_LANES];
    logic signed [ANG_W-1:0] cang  [CORDIC_LANES];
    logic                    vc;
    logic [R_W-1:0]          r_c;

    // lane 0 is atan2(y, x); lane 1 is atan2(z, hypot(x, y))
    assign cin_x[0] = R_W'($signed(xy_tag[2*CW-1:CW]));
    assign cin_y[0] = R_W'($signed(xy_tag[CW-1:0]));
    assign cin_x[1] = $signed(h_root);
    assign cin_y[1] = R_W'($signed(z_tag));

    sft_cordic #(
        .IN_W   (R_W),
        .STAGES (CORDIC_STAGES),
        .TAG_W  (R_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vr && vh),
        .in_y      (cin_y),
        .in_x      (cin_x),
        .in_tag    (r_root),
        .out_valid (vc),
        .out_ang   (cang),
        .out_tag   (r_c)
    );

    // ---------------- stage 4: range times reference ----------------
    logic                    v4_reg;
    logic [P4_W-1:0]         p4_reg;
    logic signed [ANG_W-1:0] th4_reg, ph4_reg;
    logic [R_W-1:0]          r4_reg;
    logic [R_W-1:0]          rs_c;

    // floor the range at one LSB for the scale
    assign rs_c = (r_c == '0) ? R_W'(1) : r_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= vc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_reg  <= P4_W'(rs_c) * P4_W'(range_reference_reg);
            th4_reg <= cang[0];
            ph4_reg <= cang[1];
            r4_reg  <= r_c;
        end
    end

    // ---------------- balanced scale ----------------
    logic                vs;
    logic [S_ROOT_W-1:0] s_root;
    logic [SC_TAG_W-1:0] sc_tag;

    sft_sqrt #(
        .IN_W  (P_W),
        .TAG_W (SC_TAG_W)
    ) u_sqrt_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_rad    (P_W'(p4_reg) << FRAC_BITS),
        .in_tag    ({th4_reg, ph4_reg, r4_reg}),
        .out_valid (vs),
        .out_root  (s_root),
        .out_tag   (sc_tag)
    );

    // ---------------- stage 5: scale times angle, range times gain -------
    logic signed [ANG_W-1:0] th_s, ph_s;
    logic [R_W-1:0]          r_s, rs_s;
    logic [SCALE_W-1:0]      scale_s;
    logic [ANG_W-1:0]        mag_th, mag_ph;

    logic            v5_reg;
    logic [63:0]     ath5_reg, aph5_reg;
    logic [P4_W-1:0] rr5_reg;
    logic            nth5_reg, nph5_reg;

    assign th_s    = $signed(sc_tag[SC_TAG_W-1 -: ANG_W]);
    assign ph_s    = $signed(sc_tag[R_W +: ANG_W]);
    assign r_s     = sc_tag[R_W-1:0];
    assign rs_s    = (r_s == '0) ? R_W'(1) : r_s;
    assign scale_s = balance_enable_reg ? SCALE_W'(s_root) : SCALE_W'(rs_s);
    assign mag_th  = th_s[ANG_W-1] ? ANG_W'(-th_s) : ANG_W'(th_s);
    assign mag_ph  = ph_s[ANG_W-1] ? ANG_W'(-ph_s) : ANG_W'(ph_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= vs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ath5_reg <= 64'(scale_s) * 64'(mag_th);
            aph5_reg <= 64'(scale_s) * 64'(mag_ph);
            rr5_reg  <= P4_W'(r_s) * P4_W'(range_gain_reg);
            nth5_reg <= th_s[ANG_W-1];
            nph5_reg <= ph_s[ANG_W-1];
        end
    end

    // ---------------- stage 6: gain partial products, range round -------
    logic            v6_reg;
    logic [LO_W-1:0] loth6_reg, loph6_reg;
    logic [HI_W-1:0] hith6_reg, hiph6_reg;
    logic            nth6_reg, nph6_reg;
    range_f_t        rf6_reg;
    logic [RF_W-1:0] rf_full;

    assign rf_full = (RF_W'(rr5_reg) + ROUND_RF) >> GAIN_FRAC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            loth6_reg <= LO_W'(ath5_reg[31:0]) * LO_W'(azimuth_gain_reg) + ROUND_ARC;
            loph6_reg <= LO_W'(aph5_reg[31:0]) * LO_W'(elevation_gain_reg) + ROUND_ARC;
            hith6_reg <= HI_W'(ath5_reg[63:32]) * HI_W'(azimuth_gain_reg);
            hiph6_reg <= HI_W'(aph5_reg[63:32]) * HI_W'(elevation_gain_reg);
            nth6_reg  <= nth5_reg;
            nph6_reg  <= nph5_reg;
            rf6_reg   <= (64'(rf_full) > 64'(RANGE_MAX)) ? RANGE_MAX
                                                         : RANGE_F_W'(rf_full);
        end
    end

    // ---------------- stage 7: combine, saturate, output register --------
    function automatic arc_f_t arc_sat(logic [HI_W-1:0] hi, logic [LO_W-1:0] lo,
                                       logic neg);
        logic [T_W-1:0] t;
        logic [63:0]    tw;
        logic [63:0]    lim;
        t   = (T_W'(hi) + T_W'(lo >> 32)) >> ARC_SHIFT;
        tw  = 64'(t);
        lim = 64'(1) << (ARC_F_W - 1);
        if (neg)
        begin
            if (tw > lim)
            begin
                tw = lim;
            end
            return ARC_F_W'(64'(0) - tw);
        end
        if (tw > lim - 64'(1))
        begin
            tw = lim - 64'(1);
        end
        return ARC_F_W'(tw);
    endfunction

    range_f_t range_feature_reg;
    arc_f_t   azimuth_feature_reg;
    arc_f_t   elevation_feature_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            range_feature_reg     <= rf6_reg;
            azimuth_feature_reg   <= arc_sat(hith6_reg, loth6_reg, nth6_reg);
            elevation_feature_reg <= arc_sat(hiph6_reg, loph6_reg, nph6_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), elevation_feature_reg,
                       azimuth_feature_reg, range_feature_reg};

endmodule

### design/sft_checker.sv
// ----------------------------------------------------------------------------
// Spherical feature transform port checker
// Watches the stream ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "spherical_feature_transform_top_macros.svh"

module sft_checker
    import sft_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result stays offered
    `SFT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // the pipeline takes a point exactly when its output can move
    `SFT_ASSERT(a_ready_link, s_tready == (!m_tvalid || m_tready), "input ready out of step with output")

    // a held result keeps its payload
    `SFT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // fill bits above the result fields stay clear
    `SFT_ASSERT(a_fill_zero, !m_tvalid || (m_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0), "fill bits set")

    // stall with a point offered: the consequent is true, so this never fails
    `SFT_ASSERT_NEXT(a_no_take_stalled, m_tvalid && !m_tready && s_tvalid, 1'b1, "unreachable")

endmodule

bind spherical_feature_transform_top sft_checker u_sft_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/tb_spherical_feature_transform_top.sv
// ----------------------------------------------------------------------------
// Spherical feature transform testbench
// Streams points through the block under several register settings and
// checks each feature point against a cycle-free predictor of range,
// azimuth and elevation, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_spherical_feature_transform_top;
    import sft_pkg::*;

    localparam int CW          = 24;
    localparam int FB          = 8;
    localparam int STAGES      = 24;
    localparam int IN_TDATA_W  = ((3 * CW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 120;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        range_f_t rng;
        arc_f_t   az;
        arc_f_t   el;
    } feature_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    spherical_feature_transform_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 time unit clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the register file, updated on each accepted write
    logic [15:0] ref_range_q  = 16'd2000;
    logic [15:0] range_gain_q = 16'd896;
    logic [15:0] az_gain_q    = 16'd256;
    logic [15:0] el_gain_q    = 16'd256;
    logic        balance_q    = 1'b1;

    // Arctangent table and pi, built from series sums at 62 fraction bits
    longint signed atan_tab [STAGES];
    longint signed pi_ang;

    coord_t   pending_points [$];
    feature_t expected_features [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  in_taken = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  fail_count = 0;
    int  points_sent = 0;
    int  features_checked = 0;
    int  settings_run = 0;
    longint cycles = 0;

    // atan(1/n) with 62 fraction bits
    function automatic longint unsigned atan_inv_q62(longint unsigned n);
        longint unsigned p, nn, sum, t, k;
        p = (64'd1 << 62) / n;
        nn = n * n;
        sum = 0;
        k = 0;
        while (p != 0)
        begin
            t = p / (2 * k + 1);
            if (k[0])
                sum = sum - t;
            else
                sum = sum + t;
            p = p / nn;
            k++;
        end
        return sum;
    endfunction

    function automatic void build_atan_table();
        longint unsigned q45, v;
        q45 = atan_inv_q62(2) + atan_inv_q62(3);
        atan_tab[0] = longint'((q45 + (64'd1 << 32)) >> 33);
        for (int i = 1; i < STAGES; i++)
        begin
            v = atan_inv_q62(64'd1 << i);
            atan_tab[i] = longint'((v + (64'd1 << 32)) >> 33);
        end
        pi_ang = longint'((q45 * 4 + (64'd1 << 32)) >> 33);
    endfunction

    // Square root rounded to nearest
    function automatic longint unsigned sqrt_round(bit [127:0] v);
        longint unsigned root, rem, pair, trial;
        root = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--)
        begin
            pair = 64'(v >> (2 * i)) & 64'd3;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        if (rem > root)
            root++;
        return root;
    endfunction

    // Vectoring CORDIC, 29 fraction bit radians
    function automatic longint signed vector_angle(longint signed y, longint signed x);
        longint signed base_ang, acc, dx, dy;
        base_ang = 0;
        acc = 0;
        if (y == 0)
            return (x < 0) ? pi_ang : 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base_ang = (y < 0) ? pi_ang : -pi_ang;
        end
        x = x <<< PRESCALE;
        y = y <<< PRESCALE;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                acc = acc + atan_tab[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                acc = acc - atan_tab[i];
            end
        end
        return base_ang + acc;
    endfunction

    // Round half away from zero, saturate to 40-bit two's complement
    function automatic arc_f_t weighted_arc(longint unsigned scale, longint signed ang,
                                            longint unsigned gain);
        bit [127:0]      prod;
        longint unsigned mag, t;
        bit              neg;
        neg = ang < 0;
        mag = neg ? longint'(-ang) : longint'(ang);
        prod = 128'(scale);
        prod = prod * mag;
        prod = prod * gain;
        prod = prod + (128'd1 << 36);
        t = 64'(prod >> 37);
        if (neg)
        begin
            if (t > (64'd1 << 39))
                t = 64'd1 << 39;
            return arc_f_t'(64'd0 - t);
        end
        if (t > (64'd1 << 39) - 1)
            t = (64'd1 << 39) - 1;
        return arc_f_t'(t);
    endfunction

    function automatic feature_t spherical_features(logic [IN_TDATA_W-1:0] pt);
        longint signed   x, y, z, theta, phi;
        longint unsigned ax, ay, az, sq_xy, r, h, rs, scale, rf;
        feature_t        f;
        x = longint'(coord_t'(pt[CW-1:0]));
        y = longint'(coord_t'(pt[2*CW-1:CW]));
        z = longint'(coord_t'(pt[3*CW-1:2*CW]));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        sq_xy = ax * ax + ay * ay;
        r = sqrt_round(128'(sq_xy + az * az));
        h = sqrt_round(128'(sq_xy));
        // floor the range at one LSB for the arc scale
        rs = (r != 0) ? r : 1;
        theta = vector_angle(y, x);
        phi = vector_angle(z, longint'(h));
        if (balance_q)
            scale = sqrt_round(128'(rs * ref_range_q) << FB);
        else
            scale = rs;
        rf = (r * range_gain_q + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
        if (rf > 64'(RANGE_MAX))
            rf = 64'(RANGE_MAX);
        f.rng = range_f_t'(rf);
        f.az = weighted_arc(scale, theta, az_gain_q);
        f.el = weighted_arc(scale, phi, el_gain_q);
        return f;
    endfunction

    // Input monitor and output checker, both on the rising edge
    always @(posedge clk)
    begin
        feature_t want;
        feature_t got;
        in_taken = s_tvalid && s_tready && rst_n;
        if (in_taken)
        begin
            expected_features.push_back(spherical_features(s_tdata));
            points_sent++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rng = m_tdata[RANGE_F_W-1:0];
            got.az  = m_tdata[RANGE_F_W+ARC_F_W-1:RANGE_F_W];
            got.el  = m_tdata[RANGE_F_W+2*ARC_F_W-1:RANGE_F_W+ARC_F_W];
            if (expected_features.size() == 0)
            begin
                $error("feature point with no point outstanding: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_features.pop_front();
                features_checked++;
                if (got.rng !== want.rng)
                begin
                    $error("range_feature expected %0d got %0d", want.rng, got.rng);
                    fail_count++;
                end
                if (got.az !== want.az)
                begin
                    $error("azimuth_feature expected %0d got %0d",
                           $signed(want.az), $signed(got.az));
                    fail_count++;
                end
                if (got.el !== want.el)
                begin
                    $error("elevation_feature expected %0d got %0d",
                           $signed(want.el), $signed(got.el));
                    fail_count++;
                end
            end
        end
    end

    // Point driver: advance on acceptance, idle at random
    always @(negedge clk)
    begin
        coord_t nx;
        coord_t ny;
        coord_t nz;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_points.size() >= 3 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nx = pending_points.pop_front();
                ny = pending_points.pop_front();
                nz = pending_points.pop_front();
                s_tdata  <= {nz, ny, nx};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Feature sink: random backpressure plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("spherical_feature_transform_top verification failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_RANGE_REFERENCE: ref_range_q  = value;
            CFG_RANGE_GAIN:      range_gain_q = value;
            CFG_AZIMUTH_GAIN:    az_gain_q    = value;
            CFG_ELEVATION_GAIN:  el_gain_q    = value;
            CFG_BALANCE_ENABLE:  balance_q    = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [15:0] rref, logic [15:0] rg, logic [15:0] ag,
                                 logic [15:0] eg, logic bal);
        write_reg(CFG_RANGE_REFERENCE, rref);
        write_reg(CFG_RANGE_GAIN, rg);
        write_reg(CFG_AZIMUTH_GAIN, ag);
        write_reg(CFG_ELEVATION_GAIN, eg);
        write_reg(CFG_BALANCE_ENABLE, {15'd0, bal});
        settings_run++;
    endtask

    task automatic queue_point(coord_t x, coord_t y, coord_t z);
        pending_points.push_back(x);
        pending_points.push_back(y);
        pending_points.push_back(z);
    endtask

    // Full-range and small magnitudes equally, with zero and extremes mixed in
    function automatic coord_t random_coord();
        int     pick;
        int     w;
        coord_t v;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            v = coord_t'($urandom);
        else if (pick <= 7)
        begin
            w = $urandom_range(1, CW - 2);
            v = coord_t'($urandom_range(0, (1 << w) - 1));
            if ($urandom_range(0, 1))
                v = -v;
        end
        else if (pick == 8)
            v = '0;
        else
        begin
            case ($urandom_range(0, 3))
                0:       v = {1'b1, {(CW-1){1'b0}}};
                1:       v = {1'b0, {(CW-1){1'b1}}};
                2:       v = '1;
                default: v = coord_t'(1);
            endcase
        end
        return v;
    endfunction

    // Hold until the driver has emptied its queue and all features are back
    task automatic wait_idle();
        @(posedge clk);
        while (pending_points.size() != 0 || s_tvalid || expected_features.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

    initial
    begin
        build_atan_table();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed points under reset defaults: origin, axes, extremes
        send_idle_pct = 37;
        recv_idle_pct = 70;
        queue_point(0, 0, 0);
        queue_point(5, 0, 0);
        queue_point(-5, 0, 0);
        queue_point(0, 9, 0);
        queue_point(0, -9, 0);
        queue_point(0, 0, 11);
        queue_point(0, 0, -11);
        queue_point(-1, 0, 3);
        queue_point(-1, 0, 0);
        queue_point(1, 1, 1);
        queue_point(3, -4, 12);
        queue_point(C_MAX, C_MAX, C_MAX);
        queue_point(C_MIN, C_MIN, C_MIN);
        queue_point(C_MIN, 0, 0);
        queue_point(0, C_MIN, C_MAX);
        queue_point(C_MAX, C_MIN, C_MIN);
        queue_point(-1, -1, -1);
        queue_point(C_MIN, C_MAX, 0);
        wait_idle();

        // Settings: defaults, extremes, random; saturate the arcs with full gains
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: apply_setting(16'd2000, 16'd896, 16'd256, 16'd256, 1'b1);
                1: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
                2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                3: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                4: apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 1'b0);
                default: apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom), 1'b1);
            endcase
            if (s < 2)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 70;
            end
            else if (s < 4)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 305; n++)
                queue_point(random_coord(), random_coord(), random_coord());
            // Stall the sink long enough to back the pipeline up into the input
            if (s == 4)
                hold_req = 1'b1;
            wait_idle();
        end

        $display("Covered %0d points over %0d register settings; %0d feature points checked.",
                 points_sent, settings_run, features_checked);
        if (fail_count == 0)
            $display("spherical_feature_transform_top verification clean");
        else
            $display("spherical_feature_transform_top verification failed");
        $finish;
    end

endmodule
